// ===== hw/rtl/anemometer_wind_speed_direction_top_defines.svh =====
// assertion macros for the anemometer block
`ifndef ANEMOMETER_WIND_SPEED_DIRECTION_TOP_DEFINES_SVH
`define ANEMOMETER_WIND_SPEED_DIRECTION_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define AWSD_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("awsd check failed");
// next-cycle implication
`define AWSD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("awsd check failed");
`else
`define AWSD_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define AWSD_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

// ===== hw/rtl/awsd_pkg.sv =====
package awsd_pkg;

    localparam int HIST_DEPTH = 16;
    localparam int HPTR_W     = $clog2(HIST_DEPTH);
    localparam int CNT_W      = $clog2(HIST_DEPTH + 1);

    localparam int TIME_W   = 32;
    localparam int VANE_W   = 10;
    localparam int PERIOD_W = 20;
    localparam int FACTOR_W = 16;
    localparam int OFFSET_W = 10;
    localparam int DEB_W    = 8;
    localparam int ROT_W    = 16;

    localparam int DIR_W  = 9;
    localparam int SPD_W  = 32;
    localparam int RCNT_W = 5;
    localparam int RSPD_W = 20;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 72;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 32;

    localparam logic [PERIOD_W-1:0] PERIOD_RST = 20'd1000;
    localparam logic [FACTOR_W-1:0] FACTOR_RST = 16'd501;
    localparam logic [OFFSET_W-1:0] OFFSET_RST = 10'd0;
    localparam logic [DEB_W-1:0]    DEB_RST    = 8'd15;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SAMPLE_PERIOD = 8'd0,
        CFG_SPEED_FACTOR  = 8'd1,
        CFG_VANE_OFFSET   = 8'd2,
        CFG_DEBOUNCE      = 8'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPD,
        ST_SCAN,
        ST_FIN
    } ctrl_state_t;

    typedef struct packed {
        logic [PERIOD_W-1:0] sample_period_ms;
        logic [FACTOR_W-1:0] speed_factor_q8;
        logic [DEB_W-1:0]    debounce_ms;
    } cfg_t;

    typedef struct packed {
        logic              contact_seen;
        logic [TIME_W-1:0] now_ms;
        logic [VANE_W-1:0] vane_sample;
    } item_t;

    typedef struct packed {
        logic              we;
        logic [HPTR_W-1:0] waddr;
        logic [TIME_W-1:0] wdata;
        logic              re;
        logic [HPTR_W-1:0] raddr;
    } hist_req_t;

    typedef struct packed {
        logic idle;
        logic done;
    } ctrl_stat_t;

    typedef struct packed {
        logic [SPD_W-1:0]  simple_speed_q8;
        logic [RCNT_W-1:0] rolling_count;
        logic [RSPD_W-1:0] rolling_speed_q8;
    } speed_res_t;

endpackage

// ===== hw/rtl/anemometer_wind_speed_direction_top.sv =====
// anemometer poll block: cup contact debounce, rotation latch, rolling history count, vane
// flow: accepted s_ beat, ST_UPD, ST_SCAN, then ST_FIN waits for out_free and loads m_tvalid
// one poll in flight: the next is taken once the controller is idle; the scan does one read a cycle
// the history memory port serves the newest-first walk, one entry a cycle
// reset: aresetn synchronous active low, clears state, history valid bits, config and m_tvalid
// configuration after reset: period 1000 ms, factor 501, offset 0, debounce 15 ms
`include "anemometer_wind_speed_direction_top_defines.svh"

module anemometer_wind_speed_direction_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    // input beat
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [0] contact_seen, [32:1] now_ms, [42:33] vane_sample, [47:43] zero
    input  logic [awsd_pkg::S_TDATA_W-1:0] s_tdata,
    // result beat
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [8:0] direction_deg, [40:9] simple_speed_q8, [45:41] rolling_count,
    // [65:46] rolling_speed_q8, [71:66] zero
    output logic [awsd_pkg::M_TDATA_W-1:0] m_tdata,
    // configuration write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [awsd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [awsd_pkg::CFG_DAT_W-1:0] cfg_data
);
    import awsd_pkg::*;

    localparam int RES_W = DIR_W + SPD_W + RCNT_W + RSPD_W;
    // rolling count position in the result beat and its bound
    localparam int                CNT_LSB = DIR_W + SPD_W;
    localparam logic [RCNT_W-1:0] CNT_MAX = RCNT_W'(HIST_DEPTH);

    // configuration registers
    logic [PERIOD_W-1:0] period_reg, period_next;
    logic [FACTOR_W-1:0] factor_reg, factor_next;
    logic [OFFSET_W-1:0] offset_reg, offset_next;
    logic [DEB_W-1:0]    deb_reg, deb_next;

    // output register
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic              s_accept;
    logic              out_free;
    item_t             item;
    cfg_t              cfg;
    hist_req_t         hist_req;
    logic [TIME_W-1:0] hist_rdata;
    ctrl_stat_t        stat;
    speed_res_t        res;
    logic [DIR_W-1:0]  direction_deg;

    // config writes are always taken; unknown indexes are dropped
    assign cfg_ready = 1'b1;

    always_comb begin
        period_next = period_reg;
        factor_next = factor_reg;
        offset_next = offset_reg;
        deb_next    = deb_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_SAMPLE_PERIOD: period_next = cfg_data[PERIOD_W-1:0];
                CFG_SPEED_FACTOR:  factor_next = cfg_data[FACTOR_W-1:0];
                CFG_VANE_OFFSET:   offset_next = cfg_data[OFFSET_W-1:0];
                CFG_DEBOUNCE:      deb_next    = cfg_data[DEB_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // unpack the input beat
    assign item.contact_seen = s_tdata[0];
    assign item.now_ms       = s_tdata[TIME_W:1];
    assign item.vane_sample  = s_tdata[TIME_W+VANE_W:TIME_W+1];

    assign cfg.sample_period_ms = period_reg;
    assign cfg.speed_factor_q8  = factor_reg;
    assign cfg.debounce_ms      = deb_reg;

    // one poll in flight; a held result does not block the next accept
    assign s_tready = stat.idle;
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    awsd_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (s_accept),
        .item       (item),
        .cfg        (cfg),
        .out_free   (out_free),
        .hist_rdata (hist_rdata),
        .hist_req   (hist_req),
        .stat       (stat),
        .res        (res)
    );

    awsd_hist_mem u_hist_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (hist_req),
        .rdata   (hist_rdata)
    );

    // direction is registered through prod_reg and then dir_reg, settling well before the scan ends
    awsd_dir u_dir (
        .aclk            (aclk),
        .start           (s_accept),
        .vane_sample     (item.vane_sample),
        .vane_offset_deg ($signed(offset_reg)),
        .direction_deg   (direction_deg)
    );

    // load the result beat when the controller finishes
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (stat.done) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {{(M_TDATA_W - RES_W){1'b0}}, res.rolling_speed_q8,
                             res.rolling_count, res.simple_speed_q8, direction_deg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg   <= PERIOD_RST;
            factor_reg   <= FACTOR_RST;
            offset_reg   <= OFFSET_RST;
            deb_reg      <= DEB_RST;
            m_tvalid_reg <= 1'b0;
        end else begin
            period_reg   <= period_next;
            factor_reg   <= factor_next;
            offset_reg   <= offset_next;
            deb_reg      <= deb_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // checks
    `AWSD_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_accept, !s_tready)
    `AWSD_ASSERT_IMPL(a_done_while_busy, aclk, aresetn, stat.done, !s_tready && out_free)
    `AWSD_ASSERT_NEXT(a_done_loads_beat, aclk, aresetn, stat.done, m_tvalid)
    `AWSD_ASSERT_IMPL(a_count_bound, aclk, aresetn, m_tvalid, m_tdata[CNT_LSB +: RCNT_W] <= CNT_MAX)

endmodule

// ===== hw/rtl/awsd_hist_mem.sv =====
module awsd_hist_mem (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  awsd_pkg::hist_req_t         req,
    output logic [awsd_pkg::TIME_W-1:0] rdata
);
    import awsd_pkg::*;

    logic [TIME_W-1:0]     hist_mem [HIST_DEPTH];
    logic [HIST_DEPTH-1:0] valid_reg;
    logic [HIST_DEPTH-1:0] valid_next;
    logic [TIME_W-1:0]     rdata_reg;
    logic                  rvalid_reg;

    always_comb begin
        valid_next = valid_reg;
        if (req.we) begin
            valid_next[req.waddr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (req.re) begin
                rvalid_reg <= valid_reg[req.raddr];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.we) begin
            hist_mem[req.waddr] <= req.wdata;
        end
        if (req.re) begin
            rdata_reg <= hist_mem[req.raddr];
        end
    end

    // never-written slots read as empty
    assign rdata = rvalid_reg ? rdata_reg : '0;

endmodule

// ===== hw/rtl/awsd_dir.sv =====
module awsd_dir (
    input  logic                               aclk,
    input  logic                               start,
    input  logic        [awsd_pkg::VANE_W-1:0]   vane_sample,
    input  logic signed [awsd_pkg::OFFSET_W-1:0] vane_offset_deg,
    output logic        [awsd_pkg::DIR_W-1:0]    direction_deg
);
    import awsd_pkg::*;

    logic [18:0]        prod_reg;
    logic [DIR_W-1:0]   q0;
    logic [10:0]        rem;
    logic [DIR_W-1:0]   quo;
    logic signed [10:0] dsum;
    logic signed [10:0] dwrap;
    logic [DIR_W-1:0]   dir_reg;

    // divide by 1023: shift by ten, one correction step
    always_comb begin
        q0    = prod_reg[18:10];
        rem   = {1'b0, prod_reg[9:0]} + {2'b00, q0};
        quo   = (rem >= 11'd1023) ? q0 + 1'b1 : q0;
        dsum  = $signed({2'b00, quo}) + $signed({vane_offset_deg[OFFSET_W-1], vane_offset_deg});
        dwrap = dsum;
        priority if (dsum > 11'sd720) begin
            dwrap = dsum - 11'sd720;
        end else if (dsum > 11'sd360) begin
            dwrap = dsum - 11'sd360;
        end else if (dsum < -11'sd360) begin
            dwrap = dsum + 11'sd720;
        end else if (dsum < 11'sd0) begin
            dwrap = dsum + 11'sd360;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            prod_reg <= 19'(vane_sample) * 19'd360;
        end
        dir_reg <= dwrap[DIR_W-1:0];
    end

    assign direction_deg = dir_reg;

endmodule

// ===== hw/rtl/awsd_ctrl.sv =====
module awsd_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  awsd_pkg::item_t             item,
    input  awsd_pkg::cfg_t              cfg,
    input  logic                        out_free,
    input  logic [awsd_pkg::TIME_W-1:0] hist_rdata,
    output awsd_pkg::hist_req_t         hist_req,
    output awsd_pkg::ctrl_stat_t        stat,
    output awsd_pkg::speed_res_t        res
);
    import awsd_pkg::*;

    localparam int RP_W = CNT_W + FACTOR_W;

    ctrl_state_t       state_reg, state_next;
    logic [TIME_W-1:0] now_reg, now_next;
    logic              contact_ok_reg, contact_ok_next;
    logic [TIME_W-1:0] lct_reg, lct_next;
    logic [ROT_W-1:0]  rot_reg, rot_next;
    logic [TIME_W-1:0] lll_reg, lll_next;
    logic [SPD_W-1:0]  latched_reg, latched_next;
    logic [HPTR_W-1:0] head_reg, head_next;
    logic [HPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  iss_reg, iss_next;
    logic              pend_reg, pend_next;
    logic              stop_reg, stop_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    logic [HPTR_W-1:0] head_dec;
    logic [HPTR_W-1:0] rd_ptr_inc;
    logic [ROT_W-1:0]  rot_inc;
    logic [SPD_W-1:0]  latch_prod;
    logic              latch_hit;
    logic              entry_hit;
    logic [RP_W-1:0]   roll_prod;

    assign head_dec   = (head_reg == '0) ? HPTR_W'(HIST_DEPTH - 1) : head_reg - 1'b1;
    assign rd_ptr_inc = (rd_ptr_reg == HPTR_W'(HIST_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
    assign rot_inc    = (contact_ok_reg && (rot_reg != '1)) ? rot_reg + 1'b1 : rot_reg;
    assign latch_prod = SPD_W'(rot_inc) * SPD_W'(cfg.speed_factor_q8);
    assign latch_hit  = (now_reg - lll_reg) >= TIME_W'(cfg.sample_period_ms);
    assign entry_hit  = (hist_rdata != '0)
                     && ((now_reg - hist_rdata) <= TIME_W'(cfg.sample_period_ms));
    assign roll_prod  = RP_W'(count_reg) * RP_W'(cfg.speed_factor_q8);

    always_comb begin
        state_next      = state_reg;
        now_next        = now_reg;
        contact_ok_next = contact_ok_reg;
        lct_next        = lct_reg;
        rot_next        = rot_reg;
        lll_next        = lll_reg;
        latched_next    = latched_reg;
        head_next       = head_reg;
        rd_ptr_next     = rd_ptr_reg;
        iss_next        = iss_reg;
        pend_next       = pend_reg;
        stop_next       = stop_reg;
        count_next      = count_reg;
        hist_req        = '0;
        stat            = '0;
        unique case (state_reg)
            ST_IDLE: begin
                stat.idle = 1'b1;
                if (start) begin
                    now_next        = item.now_ms;
                    contact_ok_next = item.contact_seen
                                   && ((item.now_ms - lct_reg) > TIME_W'(cfg.debounce_ms));
                    state_next      = ST_UPD;
                end
            end
            ST_UPD: begin
                if (contact_ok_reg) begin
                    lct_next       = now_reg;
                    head_next      = head_dec;
                    hist_req.we    = 1'b1;
                    hist_req.waddr = head_dec;
                    hist_req.wdata = now_reg;
                end
                rd_ptr_next = contact_ok_reg ? head_dec : head_reg;
                if (latch_hit) begin
                    lll_next     = now_reg;
                    latched_next = latch_prod;
                    rot_next     = '0;
                end else begin
                    rot_next = rot_inc;
                end
                iss_next   = '0;
                pend_next  = 1'b0;
                stop_next  = 1'b0;
                count_next = '0;
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                pend_next = 1'b0;
                if (iss_reg < CNT_W'(HIST_DEPTH)) begin
                    hist_req.re    = 1'b1;
                    hist_req.raddr = rd_ptr_reg;
                    rd_ptr_next    = rd_ptr_inc;
                    iss_next       = iss_reg + 1'b1;
                    pend_next      = 1'b1;
                end
                if (pend_reg && !stop_reg) begin
                    if (entry_hit) begin
                        count_next = count_reg + 1'b1;
                    end else begin
                        stop_next = 1'b1;
                    end
                end
                if (pend_reg && (iss_reg == CNT_W'(HIST_DEPTH))) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    stat.done  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        res.simple_speed_q8  = latched_reg;
        res.rolling_count    = (32'(count_reg) > 32'd31) ? 5'd31 : 5'(count_reg);
        res.rolling_speed_q8 = (32'(roll_prod) > 32'hFFFFF) ? 20'hFFFFF : 20'(roll_prod);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            lct_reg     <= '0;
            rot_reg     <= '0;
            lll_reg     <= '0;
            latched_reg <= '0;
            head_reg    <= '0;
            pend_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            lct_reg     <= lct_next;
            rot_reg     <= rot_next;
            lll_reg     <= lll_next;
            latched_reg <= latched_next;
            head_reg    <= head_next;
            pend_reg    <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        now_reg        <= now_next;
        contact_ok_reg <= contact_ok_next;
        rd_ptr_reg     <= rd_ptr_next;
        iss_reg        <= iss_next;
        stop_reg       <= stop_next;
        count_reg      <= count_next;
    end

endmodule
